/* hdl/cfrs_pkg.sv */
package cfrs_pkg;

  localparam int ADDR_W  = 17;
  localparam int GEN_W   = 8;
  localparam int FRAG_W  = 9;
  localparam int DONE_W  = 17;
  localparam int TOTAL_W = 16;
  localparam int ID_W    = 32;
  localparam int DELAY_W = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  // Flash layout of the stored image, in bytes
  localparam logic [ADDR_W-1:0] GEN_PREFIX_LEN    = ADDR_W'(4);
  localparam logic [FRAG_W-1:0] META_LEN          = FRAG_W'(7);
  localparam logic [ADDR_W-1:0] UPDATE_PREFIX_LEN = ADDR_W'(4);

  localparam logic [DELAY_W-1:0] MIN_PERIOD = DELAY_W'(100);

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_STOP  = 2'd1,
    CMD_TICK  = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ACT_NONE      = 2'd0,
    ACT_SEND_INIT = 2'd1,
    ACT_SEND_FRAG = 2'd2,
    ACT_SEND_TERM = 2'd3
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FLASH_VALID      = 3'd0,
    REG_GENERATION_SIZE  = 3'd1,
    REG_REDUNDANCY_SIZE  = 3'd2,
    REG_TOTAL_FRAMES     = 3'd3,
    REG_GENERATION_TOTAL = 3'd4,
    REG_FRAME_BYTES      = 3'd5,
    REG_DATA_START_ADDR  = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [1:0]         action;
    logic [ADDR_W-1:0]  fragment_address;
    logic [GEN_W-1:0]   gen_index;
    logic [FRAG_W-1:0]  frag_index;
    logic [ID_W-1:0]    tx_dest_id;
    logic               tx_multicast;
    logic [2:0]         session_code;
    logic               status;
    logic [DELAY_W-1:0] timer_period;
    logic               timer_run;
  } result_t;

endpackage

/* hdl/cfrs_in_if.sv */
interface cfrs_in_if import cfrs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic [ID_W-1:0]    dest_id;
  logic               multicast_flag;
  logic [DELAY_W-1:0] delay_ms;

  modport source (output valid, cmd, dest_id, multicast_flag, delay_ms, input ready);
  modport sink (input valid, cmd, dest_id, multicast_flag, delay_ms, output ready);
endinterface

/* hdl/cfrs_out_if.sv */
interface cfrs_out_if import cfrs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic [ADDR_W-1:0]  fragment_address;
  logic [GEN_W-1:0]   gen_index;
  logic [FRAG_W-1:0]  frag_index;
  logic [ID_W-1:0]    tx_dest_id;
  logic               tx_multicast;
  logic [2:0]         session_code;
  logic               status;
  logic [DELAY_W-1:0] timer_period;
  logic               timer_run;

  modport source (output valid, action, fragment_address, gen_index, frag_index, tx_dest_id,
                  tx_multicast, session_code, status, timer_period, timer_run,
                  input ready);
  modport sink (input valid, action, fragment_address, gen_index, frag_index, tx_dest_id,
                tx_multicast, session_code, status, timer_period, timer_run,
                output ready);
endinterface

/* hdl/coded_fragment_replay_sequencer_unit.sv */
// Replay sequencer for coded fragments stored in flash.
// in_chan (valid/ready) carries commands: start (with destination id, multicast
// flag and timer delay), stop, and timer tick. Each accepted transaction yields
// exactly one result transaction on out_chan: the action to perform (none, send
// init, send fragment, send termination), the flash byte address of the
// fragment meta, generation and fragment indices, the latched destination, the
// session code after the step, a refusal status and the tick timer control.
// cfg_we/cfg_index/cfg_wdata write the image description registers; write them
// only while no transaction is in flight.
// The result of a taken command is held in the result register, or first in the
// skid register while out_chan stalls. Throughput: one command per cycle while
// the skid register is empty; the whole step (one 9x9 multiply, a few adds and
// compares) sits between the session registers and the result register.
// Receiver stall: a two-entry output stage (result register plus skid register)
// lets one more command in while a result waits; in_chan.ready drops only once
// the skid register is full. No result is lost or repeated.
// Reset (rst_n low, synchronous): session idle, all counters, latched values and
// configuration registers cleared, output stage empty.
module coded_fragment_replay_sequencer_unit import cfrs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  cfrs_in_if.sink               in_chan,
  cfrs_out_if.source            out_chan,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  typedef enum logic [2:0] {
    S_IDLE     = 3'd0,
    S_PRE_INIT = 3'd1,
    S_IN_GEN   = 3'd2,
    S_UPDATE   = 3'd3,
    S_PRE_TERM = 3'd4,
    S_POST_TERM = 3'd5
  } sess_t;

  // Configuration registers
  logic                flash_valid_r;
  logic [GEN_W-1:0]    generation_size_r;
  logic [GEN_W-1:0]    redundancy_size_r;
  logic [TOTAL_W-1:0]  total_frames_r;
  logic [GEN_W-1:0]    generation_total_r;
  logic [7:0]          frame_bytes_r;
  logic [ADDR_W-1:0]   data_start_addr_r;

  // Session state
  sess_t               session_r, session_nxt;
  logic [GEN_W-1:0]    gen_cnt_r, gen_cnt_nxt;
  logic [FRAG_W-1:0]   frag_cnt_r, frag_cnt_nxt;
  logic [DONE_W-1:0]   frames_done_r, frames_done_nxt;
  logic [ADDR_W-1:0]   gen_base_r, gen_base_nxt;
  logic [ID_W-1:0]     dest_r, dest_nxt;
  logic                mcast_r, mcast_nxt;
  logic [DELAY_W-1:0]  delay_r, delay_nxt;

  // Output stage
  logic    out_valid_r, skid_valid_r;
  result_t out_data_r, skid_data_r;
  result_t res;

  logic accept;
  assign in_chan.ready = !skid_valid_r;
  assign accept        = in_chan.valid && in_chan.ready;

  // Generation geometry
  logic [DONE_W-1:0]     left_full;
  logic [TOTAL_W-1:0]    left;
  logic [GEN_W-1:0]      base_cnt;
  logic [FRAG_W-1:0]     gen_frames;
  logic [FRAG_W-1:0]     stride;
  logic [FRAG_W-1:0]     mul_a;
  logic [2*FRAG_W-1:0]   prod;
  logic [ADDR_W-1:0]     frag_addr;
  logic [DONE_W:0]       done_sum;
  logic                  last_frag;
  logic                  more_gens;

  always_comb begin
    left_full  = DONE_W'(total_frames_r) - frames_done_r;
    left       = (DONE_W'(total_frames_r) > frames_done_r) ? left_full[TOTAL_W-1:0] : '0;
    base_cnt   = (TOTAL_W'(generation_size_r) <= left) ? generation_size_r : left[GEN_W-1:0];
    gen_frames = FRAG_W'(base_cnt) + FRAG_W'(redundancy_size_r);
    stride     = FRAG_W'(frame_bytes_r) + META_LEN;
    // Share one multiplier: fragment offset while sending, generation length
    // while moving to the next generation
    mul_a      = (session_r == S_UPDATE) ? gen_frames : frag_cnt_r;
    prod       = (2*FRAG_W)'(mul_a) * (2*FRAG_W)'(stride);
    frag_addr  = gen_base_r + GEN_PREFIX_LEN + prod[ADDR_W-1:0];
    done_sum   = (DONE_W+1)'(frames_done_r) + (DONE_W+1)'(generation_size_r);
    last_frag  = ((FRAG_W+1)'(frag_cnt_r) + (FRAG_W+1)'(1)) >= (FRAG_W+1)'(gen_frames);
    more_gens  = ((GEN_W+1)'(gen_cnt_r) + (GEN_W+1)'(1)) < (GEN_W+1)'(generation_total_r);
  end

  // One step of the session
  always_comb begin
    logic sent_frag;
    logic run;
    sent_frag       = 1'b0;
    session_nxt     = session_r;
    gen_cnt_nxt     = gen_cnt_r;
    frag_cnt_nxt    = frag_cnt_r;
    frames_done_nxt = frames_done_r;
    gen_base_nxt    = gen_base_r;
    dest_nxt        = dest_r;
    mcast_nxt       = mcast_r;
    delay_nxt       = delay_r;
    res             = '0;
    res.action      = ACT_NONE;
    run             = (session_r != S_IDLE);

    case (in_chan.cmd)
      CMD_START: begin
        if (!flash_valid_r) begin
          res.status = 1'b1;
        end else begin
          dest_nxt        = in_chan.dest_id;
          mcast_nxt       = in_chan.multicast_flag;
          delay_nxt       = in_chan.delay_ms;
          session_nxt     = S_PRE_INIT;
          gen_cnt_nxt     = '0;
          frag_cnt_nxt    = '0;
          frames_done_nxt = '0;
          gen_base_nxt    = data_start_addr_r;
          run             = 1'b1;
        end
      end
      CMD_STOP: begin
        session_nxt = S_PRE_TERM;
        run         = 1'b0;
      end
      CMD_TICK: begin
        unique case (session_r)
          S_PRE_INIT: begin
            res.action  = ACT_SEND_INIT;
            session_nxt = S_IN_GEN;
          end
          S_IN_GEN: begin
            res.action           = ACT_SEND_FRAG;
            res.fragment_address = frag_addr;
            sent_frag            = 1'b1;
            if (last_frag) begin
              session_nxt = more_gens ? S_UPDATE : S_PRE_TERM;
            end else begin
              frag_cnt_nxt = frag_cnt_r + FRAG_W'(1);
            end
          end
          S_UPDATE: begin
            gen_base_nxt    = gen_base_r + GEN_PREFIX_LEN + prod[ADDR_W-1:0] +
                              UPDATE_PREFIX_LEN;
            frames_done_nxt = done_sum[DONE_W] ? '1 : done_sum[DONE_W-1:0];
            gen_cnt_nxt     = gen_cnt_r + GEN_W'(1);
            frag_cnt_nxt    = '0;
            session_nxt     = S_IN_GEN;
          end
          S_PRE_TERM: begin
            res.action  = ACT_SEND_TERM;
            session_nxt = S_POST_TERM;
          end
          default: begin
            session_nxt = S_IDLE;
          end
        endcase
        run = (session_nxt != S_IDLE);
      end
      default: begin
      end
    endcase

    // Indices report the sent fragment, else the counters after the step
    res.gen_index    = sent_frag ? gen_cnt_r : gen_cnt_nxt;
    res.frag_index   = sent_frag ? frag_cnt_r : frag_cnt_nxt;
    res.tx_dest_id   = dest_nxt;
    res.tx_multicast = mcast_nxt;
    res.session_code = session_nxt;
    res.timer_period = (delay_nxt > MIN_PERIOD) ? delay_nxt : MIN_PERIOD;
    res.timer_run    = run;
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flash_valid_r      <= 1'b0;
      generation_size_r  <= '0;
      redundancy_size_r  <= '0;
      total_frames_r     <= '0;
      generation_total_r <= '0;
      frame_bytes_r      <= '0;
      data_start_addr_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FLASH_VALID:      flash_valid_r      <= cfg_wdata[0];
        REG_GENERATION_SIZE:  generation_size_r  <= cfg_wdata[GEN_W-1:0];
        REG_REDUNDANCY_SIZE:  redundancy_size_r  <= cfg_wdata[GEN_W-1:0];
        REG_TOTAL_FRAMES:     total_frames_r     <= cfg_wdata[TOTAL_W-1:0];
        REG_GENERATION_TOTAL: generation_total_r <= cfg_wdata[GEN_W-1:0];
        REG_FRAME_BYTES:      frame_bytes_r      <= cfg_wdata[7:0];
        REG_DATA_START_ADDR:  data_start_addr_r  <= cfg_wdata[ADDR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Session state: advance on every accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      session_r     <= S_IDLE;
      gen_cnt_r     <= '0;
      frag_cnt_r    <= '0;
      frames_done_r <= '0;
      gen_base_r    <= '0;
      dest_r        <= '0;
      mcast_r       <= 1'b0;
      delay_r       <= '0;
    end else if (accept) begin
      session_r     <= session_nxt;
      gen_cnt_r     <= gen_cnt_nxt;
      frag_cnt_r    <= frag_cnt_nxt;
      frames_done_r <= frames_done_nxt;
      gen_base_r    <= gen_base_nxt;
      dest_r        <= dest_nxt;
      mcast_r       <= mcast_nxt;
      delay_r       <= delay_nxt;
    end
  end

  // Output stage: result register backed by a skid register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_chan.ready) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= accept;
      end
    end else if (accept) begin
      skid_valid_r <= 1'b1;
    end
  end

  // Payload: no reset needed
  always_ff @(posedge clk) begin
    if (!out_valid_r || out_chan.ready) begin
      if (skid_valid_r) begin
        out_data_r <= skid_data_r;
      end else if (accept) begin
        out_data_r <= res;
      end
    end else if (accept) begin
      skid_data_r <= res;
    end
  end

  assign out_chan.valid            = out_valid_r;
  assign out_chan.action           = out_data_r.action;
  assign out_chan.fragment_address = out_data_r.fragment_address;
  assign out_chan.gen_index        = out_data_r.gen_index;
  assign out_chan.frag_index       = out_data_r.frag_index;
  assign out_chan.tx_dest_id       = out_data_r.tx_dest_id;
  assign out_chan.tx_multicast     = out_data_r.tx_multicast;
  assign out_chan.session_code     = out_data_r.session_code;
  assign out_chan.status           = out_data_r.status;
  assign out_chan.timer_period     = out_data_r.timer_period;
  assign out_chan.timer_run        = out_data_r.timer_run;

endmodule
